// ----- sv/binomial_mod_prime_macros.svh -----
// Assertion macros for the binomial_mod_prime block.
`ifndef BINOMIAL_MOD_PRIME_MACROS_SVH
`define BINOMIAL_MOD_PRIME_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BMP_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("binomial_mod_prime: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define BMP_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("binomial_mod_prime: next-cycle check failed");

`endif

// ----- sv/bmp_pkg.sv -----
// Shared constants, types and command/status structs of the binomial block.
`default_nettype none

package bmp_pkg;

	localparam int MODULUS = 10007;
	localparam int IN_W    = 14;
	localparam int OUT_W   = 14;
	localparam int RES_W   = $clog2(MODULUS);
	localparam int OP_W    = (RES_W > IN_W) ? RES_W : IN_W;
	localparam int P_W     = 2 * OP_W;
	// Barrett reduction: SHIFT makes the quotient estimate exact for any P_W-bit product
	localparam int SHIFT   = P_W + RES_W + 1;
	localparam int R_W     = SHIFT - RES_W + 2;
	localparam int PR_W    = P_W + R_W;
	localparam int Q_W     = PR_W - SHIFT;

	localparam longint unsigned RECIP_L =
		((64'd1 << SHIFT) + 64'(MODULUS) - 64'd1) / 64'(MODULUS);

	localparam logic [R_W-1:0]   RECIP    = R_W'(RECIP_L);
	localparam logic [P_W-1:0]   MOD_P    = P_W'(MODULUS);
	localparam logic [RES_W-1:0] MOD_MAX  = RES_W'(MODULUS - 1);
	localparam logic [RES_W-1:0] RES_ONE  = RES_W'(1);
	localparam logic [OP_W-1:0]  OP_ONE   = OP_W'(1);
	// Fermat exponent for the inverse
	localparam logic [RES_W-1:0] EXPONENT = RES_W'(MODULUS - 2);

	typedef enum logic [2:0] {
		OP_REDUCE  = 3'd0,
		OP_NUM     = 3'd1,
		OP_DEN     = 3'd2,
		OP_EXP_MUL = 3'd3,
		OP_EXP_SQR = 3'd4,
		OP_FINAL   = 3'd5
	} op_t;

	typedef struct packed {
		logic issue;
		op_t  op;
		logic load_in;
		logic step_fac;
		logic step_exp;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic cnt_zero;
		logic exp_bit;
		logic exp_done;
		logic out_free;
		logic pipe_idle;
	} sts_t;

endpackage

`default_nettype wire

// ----- sv/binomial_mod_prime.sv -----
// Top level of binomial_mod_prime: C(total_count, choose_count) reduced modulo the prime
// MODULUS (10007). Each input beat carries a pair (n, k) and yields exactly one output
// beat. A chosen count above the total gives 0; otherwise k is folded to min(k, n - k)
// and the numerator product n*(n-1)*... and the denominator product 1*2*...*k are built
// side by side, each factor reduced modulo the prime. Rather than inverting every
// denominator factor, the whole denominator product is inverted once by Fermat
// square-and-multiply (power MODULUS - 2), which gives the same residue, 0 included when
// a denominator factor is a multiple of the prime. Totals at or above the prime use the
// same product formula with every numerator factor reduced. All arithmetic runs through
// one three-stage modular multiplier (product, Barrett quotient, exact remainder), whose
// latency sets the pace of each factor and each exponent bit. The controller takes no
// new pair before it is through with the last one, and an item may also wait for the
// output register. in_ready is high only while the controller is idle; the result sits
// in an output register, so a new pair is taken while the previous result still waits,
// and the controller holds its next result until that register is free.
`default_nettype none
`include "binomial_mod_prime_macros.svh"

module binomial_mod_prime (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [bmp_pkg::IN_W-1:0]  total_count,
	input  wire logic [bmp_pkg::IN_W-1:0]  choose_count,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [bmp_pkg::OUT_W-1:0]      binomial_residue
);
	import bmp_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencing of the multiplier and counters
	bmp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	// operands, multiplier, counters and the output register
	bmp_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.total_count      (total_count),
		.choose_count     (choose_count),
		.out_ready        (out_ready),
		.sts              (sts),
		.out_valid        (out_valid),
		.binomial_residue (binomial_residue)
	);

	// idle controller means nothing is left in flight in the multiplier
	`BMP_ASSERT_IMPL(a_idle_pipe_empty, in_ready, sts.pipe_idle)
	// an accepted beat moves the controller out of idle straight away
	`BMP_ASSERT_NEXT(a_accept_leaves_idle, in_valid && in_ready, !in_ready)
	// never overwrite a result that has not been taken
	`BMP_ASSERT_IMPL(a_load_needs_room, cmd.load_out, !out_valid || out_ready)
	// a delivered residue is always reduced
	`BMP_ASSERT_IMPL(a_residue_reduced, out_valid, int'(binomial_residue) < MODULUS)

endmodule

`default_nettype wire

// ----- sv/bmp_modmul.sv -----
// Three-stage pipelined modular multiplier with Barrett reduction.
`default_nettype none

module bmp_modmul (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    issue,
	input  wire bmp_pkg::op_t            op,
	input  wire logic [bmp_pkg::OP_W-1:0] a,
	input  wire logic [bmp_pkg::OP_W-1:0] b,
	output logic                         res_vld,
	output bmp_pkg::op_t                 res_op,
	output logic [bmp_pkg::RES_W-1:0]    res,
	output logic                         idle
);
	import bmp_pkg::*;

	logic           vld_s1, vld_s2;
	op_t            op_s1, op_s2;
	logic [P_W-1:0] p_s1, p_s2;
	logic [Q_W-1:0] q_s2;
	logic [PR_W-1:0] pr;
	logic [P_W-1:0] rem;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
		end
	end

	assign pr = PR_W'(p_s1) * PR_W'(RECIP);

	always_ff @(posedge clk) begin
		p_s1  <= P_W'(a) * P_W'(b);
		op_s1 <= op;
		p_s2  <= p_s1;
		q_s2  <= pr[PR_W-1:SHIFT];
		op_s2 <= op_s1;
	end

	// quotient is exact, so one subtract leaves the residue
	assign rem     = p_s2 - P_W'(q_s2) * MOD_P;
	assign res     = rem[RES_W-1:0];
	assign res_vld = vld_s2;
	assign res_op  = op_s2;
	assign idle    = !vld_s1 && !vld_s2;

endmodule

`default_nettype wire

// ----- sv/bmp_datapath.sv -----
// Datapath: operand registers, factor counters, exponent shifter, output register.
`default_nettype none

module bmp_datapath (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire bmp_pkg::cmd_t            cmd,
	input  wire logic [bmp_pkg::IN_W-1:0] total_count,
	input  wire logic [bmp_pkg::IN_W-1:0] choose_count,
	input  wire logic                     out_ready,
	output bmp_pkg::sts_t                 sts,
	output logic                          out_valid,
	output logic [bmp_pkg::OUT_W-1:0]     binomial_residue
);
	import bmp_pkg::*;

	logic [IN_W-1:0]  n_q, cnt_q;
	logic [RES_W-1:0] num_q, den_q, inv_q, nfac_q, dfac_q, exp_sr_q;
	logic [OUT_W-1:0] res_q;
	logic             out_vld_q;

	logic [IN_W:0]    diff;
	logic             k_gt;
	logic [IN_W-1:0]  n_minus_k, k_eff;

	logic [OP_W-1:0]  opa, opb;
	logic             mm_vld, mm_idle;
	op_t              mm_op;
	logic [RES_W-1:0] mm_res;

	// fold the chosen count onto the smaller side
	assign diff      = {1'b0, total_count} - {1'b0, choose_count};
	assign k_gt      = diff[IN_W];
	assign n_minus_k = diff[IN_W-1:0];
	assign k_eff     = k_gt ? '0 : ((choose_count > n_minus_k) ? n_minus_k : choose_count);

	always_comb begin
		opa = '0;
		opb = '0;
		case (cmd.op)
			OP_REDUCE: begin
				opa = OP_W'(n_q);
				opb = OP_ONE;
			end
			OP_NUM: begin
				opa = OP_W'(num_q);
				opb = OP_W'(nfac_q);
			end
			OP_DEN: begin
				opa = OP_W'(den_q);
				opb = OP_W'(dfac_q);
			end
			OP_EXP_MUL: begin
				opa = OP_W'(inv_q);
				opb = OP_W'(den_q);
			end
			OP_EXP_SQR: begin
				opa = OP_W'(den_q);
				opb = OP_W'(den_q);
			end
			OP_FINAL: begin
				opa = OP_W'(num_q);
				opb = OP_W'(inv_q);
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	bmp_modmul u_modmul (
		.clk     (clk),
		.arst_n  (arst_n),
		.issue   (cmd.issue),
		.op      (cmd.op),
		.a       (opa),
		.b       (opb),
		.res_vld (mm_vld),
		.res_op  (mm_op),
		.res     (mm_res),
		.idle    (mm_idle)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			n_q      <= total_count;
			cnt_q    <= k_eff;
			num_q    <= k_gt ? '0 : RES_ONE;
			den_q    <= RES_ONE;
			inv_q    <= RES_ONE;
			dfac_q   <= RES_ONE;
			exp_sr_q <= EXPONENT;
		end else begin
			if (cmd.step_fac) begin
				cnt_q  <= cnt_q - IN_W'(1);
				nfac_q <= (nfac_q == '0) ? MOD_MAX : nfac_q - RES_ONE;
				dfac_q <= (dfac_q == MOD_MAX) ? '0 : dfac_q + RES_ONE;
			end
			if (cmd.step_exp) begin
				exp_sr_q <= exp_sr_q >> 1;
			end
			if (mm_vld) begin
				case (mm_op)
					OP_REDUCE:  nfac_q <= mm_res;
					OP_NUM:     num_q  <= mm_res;
					OP_FINAL:   num_q  <= mm_res;
					OP_DEN:     den_q  <= mm_res;
					OP_EXP_SQR: den_q  <= mm_res;
					OP_EXP_MUL: inv_q  <= mm_res;
					default:    inv_q  <= inv_q;
				endcase
			end
		end
		if (cmd.load_out) begin
			res_q <= OUT_W'(num_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign sts.cnt_zero  = (cnt_q == '0);
	assign sts.exp_bit   = exp_sr_q[0];
	assign sts.exp_done  = (exp_sr_q == '0);
	assign sts.out_free  = !out_vld_q || out_ready;
	assign sts.pipe_idle = mm_idle;

	assign out_valid        = out_vld_q;
	assign binomial_residue = res_q;

endmodule

`default_nettype wire

// ----- sv/bmp_ctrl.sv -----
// Controller: sequences reduction, factor products, Fermat inverse and final product.
`default_nettype none

module bmp_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire bmp_pkg::sts_t sts,
	output logic               in_ready,
	output bmp_pkg::cmd_t      cmd
);
	import bmp_pkg::*;

	typedef enum logic [15:0] {
		S_IDLE       = 16'h0001,
		S_RED        = 16'h0002,
		S_RED_W1     = 16'h0004,
		S_RED_W2     = 16'h0008,
		S_FAC_NUM    = 16'h0010,
		S_FAC_DEN    = 16'h0020,
		S_FAC_GAP    = 16'h0040,
		S_EXP_SETTLE = 16'h0080,
		S_EXP_MUL    = 16'h0100,
		S_EXP_SQR    = 16'h0200,
		S_EXP_W1     = 16'h0400,
		S_EXP_W2     = 16'h0800,
		S_FIN_MUL    = 16'h1000,
		S_FIN_W1     = 16'h2000,
		S_FIN_W2     = 16'h4000,
		S_FIN_OUT    = 16'h8000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.op       = OP_NUM;
		case (state_q)
			S_IDLE: begin
				cmd.load_in = in_valid;
				if (in_valid) state_d = S_RED;
			end
			S_RED: begin
				cmd.issue = 1'b1;
				cmd.op    = OP_REDUCE;
				state_d   = S_RED_W1;
			end
			S_RED_W1: state_d = S_RED_W2;
			S_RED_W2: state_d = sts.cnt_zero ? S_EXP_MUL : S_FAC_NUM;
			S_FAC_NUM: begin
				cmd.issue = 1'b1;
				cmd.op    = OP_NUM;
				state_d   = S_FAC_DEN;
			end
			S_FAC_DEN: begin
				cmd.issue    = 1'b1;
				cmd.op       = OP_DEN;
				cmd.step_fac = 1'b1;
				state_d      = S_FAC_GAP;
			end
			// numerator and denominator products are both back in time for the next factor
			S_FAC_GAP:    state_d = sts.cnt_zero ? S_EXP_SETTLE : S_FAC_NUM;
			S_EXP_SETTLE: state_d = S_EXP_MUL;
			S_EXP_MUL: begin
				cmd.issue = sts.exp_bit;
				cmd.op    = OP_EXP_MUL;
				state_d   = S_EXP_SQR;
			end
			S_EXP_SQR: begin
				cmd.issue    = 1'b1;
				cmd.op       = OP_EXP_SQR;
				cmd.step_exp = 1'b1;
				state_d      = S_EXP_W1;
			end
			S_EXP_W1: state_d = S_EXP_W2;
			S_EXP_W2: state_d = sts.exp_done ? S_FIN_MUL : S_EXP_MUL;
			S_FIN_MUL: begin
				cmd.issue = 1'b1;
				cmd.op    = OP_FINAL;
				state_d   = S_FIN_W1;
			end
			S_FIN_W1: state_d = S_FIN_W2;
			S_FIN_W2: state_d = S_FIN_OUT;
			S_FIN_OUT: begin
				// hold until the output register has room
				cmd.load_out = sts.out_free;
				if (sts.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

`default_nettype wire
